FILE: sv/gnd_pkg.sv
// Shared constants, types and structs for the note dispenser.
`timescale 1ns / 1ps
package gnd_pkg;

    localparam int NOTE_SLOTS = 6;
    localparam int IDX_W      = $clog2(NOTE_SLOTS);
    localparam int CFG_IDX_W  = IDX_W;
    localparam int DENOM_W    = 20;
    localparam int STOCK_W    = 16;
    localparam int VALUE_W    = 36;
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(VALUE_W);

    localparam logic [CMD_W-1:0] CMD_WITHDRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_STOCK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_CASH  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_PAID    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LOADED  = 2'd2;

    localparam logic [DENOM_W-1:0] DENOM_RESET [NOTE_SLOTS] = '{
        20'd10000, 20'd20000, 20'd50000, 20'd100000, 20'd200000, 20'd500000
    };

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [DENOM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DENOM_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: sv/gnd_if.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
interface gnd_in_if;
    logic                         valid;
    logic                         ready;
    logic [gnd_pkg::CMD_W-1:0]    cmd;
    logic [gnd_pkg::SLOT_W-1:0]   slot;
    logic [gnd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output slot, output value, input ready);
    modport sink   (input valid, input cmd, input slot, input value, output ready);
endinterface

interface gnd_out_if;
    logic                          valid;
    logic                          ready;
    logic [gnd_pkg::STATUS_W-1:0]  status;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot0;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot1;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot2;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot3;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot4;
    logic [gnd_pkg::STOCK_W-1:0]   notes_slot5;
    logic [gnd_pkg::VALUE_W-1:0]   paid_total;
    logic [gnd_pkg::DENOM_W-1:0]   smallest_note;

    modport source (output valid, output status, output notes_slot0, output notes_slot1,
                    output notes_slot2, output notes_slot3, output notes_slot4,
                    output notes_slot5, output paid_total, output smallest_note,
                    input ready);
    modport sink   (input valid, input status, input notes_slot0, input notes_slot1,
                    input notes_slot2, input notes_slot3, input notes_slot4,
                    input notes_slot5, input paid_total, input smallest_note,
                    output ready);
endinterface

FILE: sv/gnd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gnd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gnd_pkg::div_req_t req,
    output gnd_pkg::div_rsp_t rsp
);
    import gnd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0]   dvd_reg;
    logic [VALUE_W-1:0]   quo_reg;
    logic [DENOM_W-1:0]   part_reg;
    logic [DENOM_W-1:0]   dsr_reg;

    logic [DENOM_W:0]     shifted;
    logic [DENOM_W:0]     diff;
    logic                 ge;
    logic [DENOM_W-1:0]   part_next;

    assign shifted   = {part_reg, dvd_reg[VALUE_W-1]};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign ge        = shifted >= {1'b0, dsr_reg};
    assign part_next = ge ? diff[DENOM_W-1:0] : shifted[DENOM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(VALUE_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= req.dividend;
            dsr_reg  <= req.divisor;
            quo_reg  <= '0;
            part_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[VALUE_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[VALUE_W-2:0], ge};
            part_reg <= part_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = part_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dsr_reg != '0) |-> (part_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (busy_reg && !done_reg))
        else $error("divider did not start");

    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

endmodule

FILE: sv/greedy_note_dispenser.sv
// Top level: note stock, cash total and the withdraw sequencer.
`timescale 1ns / 1ps
// Load commands, unknown commands and withdraws above the cash total go straight to the done
//   state, which loads the result word into the output register once that register is free.
// Withdraw: per slot a setup state launches the divide, the divider builds the quotient bit by bit,
//   a cap state clamps the count to the stock and a subtract state follows when the stock caps it
//   (denomination 0 slots skip the divide). One word at a time: the next is taken in idle.
// Reset: stocks and cash total clear to zero, denominations return to their defaults.
module greedy_note_dispenser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gnd_pkg::DENOM_W-1:0]      cfg_data,
    gnd_in_if.sink                           req,
    gnd_out_if.source                        rsp
);
    import gnd_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SLOT   = 8'b0000_0010,  // pick next slot, launch divide
        ST_DIV    = 8'b0000_0100,  // wait on divider
        ST_CAP    = 8'b0000_1000,  // clamp count to stock
        ST_SUB    = 8'b0001_0000,  // remainder minus capped payout
        ST_EVAL   = 8'b0010_0000,  // exact payout?
        ST_COMMIT = 8'b0100_0000,  // drop stock and cash
        ST_DONE   = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t               state_reg, state_next;

    logic [DENOM_W-1:0]   denom_reg [NOTE_SLOTS];
    logic [STOCK_W-1:0]   stock_reg [NOTE_SLOTS];
    logic [VALUE_W-1:0]   cash_reg;

    // Per-word working registers
    logic [VALUE_W-1:0]   amount_reg;
    logic [VALUE_W-1:0]   rem_reg;
    logic [VALUE_W-1:0]   prod_reg;
    logic [DENOM_W-1:0]   d_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STOCK_W-1:0]   take_reg [NOTE_SLOTS];

    // Output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [STOCK_W-1:0]   out_notes_reg [NOTE_SLOTS];
    logic [VALUE_W-1:0]   out_paid_reg;
    logic [DENOM_W-1:0]   out_small_reg;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 accept;
    logic                 out_load;
    logic                 last_slot;
    logic [DENOM_W-1:0]   cur_denom;
    logic [STOCK_W-1:0]   cur_stock;
    logic                 over_stock;
    logic [DENOM_W-1:0]   smallest;
    logic                 found;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign last_slot  = (idx_reg == '0);
    assign cur_denom  = denom_reg[idx_reg];
    assign cur_stock  = stock_reg[idx_reg];
    assign over_stock = div_rsp.quotient > {{(VALUE_W-STOCK_W){1'b0}}, cur_stock};

    // The one divider: divides the running remainder by the current slot's note.
    assign div_req.start    = (state_reg == ST_SLOT) && (cur_denom != '0);
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = cur_denom;

    gnd_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Lowest slot with stock left; read after the step's update has landed.
    always_comb
    begin
        smallest = '0;
        found    = 1'b0;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            if (!found && stock_reg[i] != '0)
            begin
                smallest = denom_reg[i];
                found    = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_WITHDRAW && req.value <= cash_reg)
                        state_next = ST_SLOT;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SLOT:
            begin
                if (cur_denom != '0)
                    state_next = ST_DIV;
                else if (last_slot)
                    state_next = ST_EVAL;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_CAP;
            end
            ST_CAP:
            begin
                if (over_stock)
                    state_next = ST_SUB;
                else if (last_slot)
                    state_next = ST_EVAL;
                else
                    state_next = ST_SLOT;
            end
            ST_SUB:
            begin
                state_next = last_slot ? ST_EVAL : ST_SLOT;
            end
            ST_EVAL:
            begin
                state_next = (rem_reg == '0) ? ST_COMMIT : ST_DONE;
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cash_reg      <= '0;
            for (int i = 0; i < NOTE_SLOTS; i++)
            begin
                denom_reg[i] <= DENOM_RESET[i];
                stock_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en && cfg_index < CFG_IDX_W'(NOTE_SLOTS))
                denom_reg[cfg_index] <= cfg_data;

            if (accept && req.cmd == CMD_SET_STOCK && req.slot < SLOT_W'(NOTE_SLOTS))
                stock_reg[req.slot[IDX_W-1:0]] <= (|req.value[VALUE_W-1:STOCK_W]) ?
                                                  '1 : req.value[STOCK_W-1:0];

            if (accept && req.cmd == CMD_SET_CASH)
                cash_reg <= req.value;

            if (state_reg == ST_COMMIT)
            begin
                cash_reg <= cash_reg - amount_reg;
                for (int i = 0; i < NOTE_SLOTS; i++)
                    stock_reg[i] <= stock_reg[i] - take_reg[i];
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    amount_reg <= req.value;
                    rem_reg    <= req.value;
                    idx_reg    <= IDX_W'(NOTE_SLOTS - 1);
                    for (int i = 0; i < NOTE_SLOTS; i++)
                        take_reg[i] <= '0;
                    priority if (req.cmd == CMD_WITHDRAW)
                        status_reg <= STAT_REFUSED;  // stays unless paid exactly
                    else if (req.cmd == CMD_SET_STOCK || req.cmd == CMD_SET_CASH)
                        status_reg <= STAT_LOADED;
                    else
                        status_reg <= STAT_REFUSED;
                end
            end
            ST_SLOT:
            begin
                d_reg <= cur_denom;
                if (cur_denom == '0 && !last_slot)
                    idx_reg <= idx_reg - 1'b1;
            end
            ST_DIV:
            begin
            end
            ST_CAP:
            begin
                if (over_stock)
                begin
                    take_reg[idx_reg] <= cur_stock;
                    prod_reg          <= VALUE_W'(cur_stock * d_reg);
                end
                else
                begin
                    take_reg[idx_reg] <= div_rsp.quotient[STOCK_W-1:0];
                    rem_reg           <= {{(VALUE_W-DENOM_W){1'b0}}, div_rsp.remainder};
                    if (!last_slot)
                        idx_reg <= idx_reg - 1'b1;
                end
            end
            ST_SUB:
            begin
                rem_reg <= rem_reg - prod_reg;
                if (!last_slot)
                    idx_reg <= idx_reg - 1'b1;
            end
            ST_EVAL:
            begin
                if (rem_reg == '0)
                    status_reg <= STAT_PAID;
                else
                    for (int i = 0; i < NOTE_SLOTS; i++)
                        take_reg[i] <= '0;
            end
            ST_COMMIT:
            begin
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_status_reg <= status_reg;
                    out_paid_reg   <= (status_reg == STAT_PAID) ? amount_reg : '0;
                    out_small_reg  <= smallest;
                    for (int i = 0; i < NOTE_SLOTS; i++)
                        out_notes_reg[i] <= take_reg[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.notes_slot0   = out_notes_reg[0];
    assign rsp.notes_slot1   = out_notes_reg[1];
    assign rsp.notes_slot2   = out_notes_reg[2];
    assign rsp.notes_slot3   = out_notes_reg[3];
    assign rsp.notes_slot4   = out_notes_reg[4];
    assign rsp.notes_slot5   = out_notes_reg[5];
    assign rsp.paid_total    = out_paid_reg;
    assign rsp.smallest_note = out_small_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_commit_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> (rem_reg == '0 && amount_reg <= cash_reg))
        else $error("commit without exact payout");

    generate
        for (genvar g = 0; g < NOTE_SLOTS; g++)
        begin : g_take_chk
            a_take_le_stock: assert property (@(posedge clk) disable iff (!rst_n)
                (state_reg == ST_COMMIT) |-> (take_reg[g] <= stock_reg[g]))
                else $error("payout exceeds slot stock");
        end
    endgenerate

    a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside done state");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the greedy note dispenser: directed and random command words.
`timescale 1ns / 1ps
module tb_top;
    import gnd_pkg::*;

    // Command code 3 has no name in the package; the block must refuse it.
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;
    localparam logic [VALUE_W-1:0] STOCK_CAP  = 36'd65535;
    localparam logic [DENOM_W-1:0] DENOM_MAX  = '1;

    // Denomination sets used by the configuration phases.
    localparam logic [DENOM_W-1:0] DENOM_COINS [NOTE_SLOTS] = '{
        20'd1, 20'd2, 20'd5, 20'd10, 20'd20, 20'd50
    };
    // Smallest, zero and largest denominations mixed, out of order.
    localparam logic [DENOM_W-1:0] DENOM_EDGES [NOTE_SLOTS] = '{
        20'd1, 20'd0, 20'hFFFFF, 20'd3, 20'hFFFFF, 20'hFFFFE
    };

    localparam int     PHASES       = 8;
    localparam int     PHASE_WORDS  = 175;
    // Wait after the last phase, longer than the longest withdraw; room for a stray late word.
    localparam int     DRAIN_CYCLES = 300;
    localparam longint LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]                  status;
        logic [NOTE_SLOTS-1:0][STOCK_W-1:0]   notes;
        logic [VALUE_W-1:0]                   paid;
        logic [DENOM_W-1:0]                   smallest;
    } payout_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DENOM_W-1:0]     cfg_data;

    gnd_in_if  req_if ();
    gnd_out_if rsp_if ();

    greedy_note_dispenser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Dispenser state as the testbench sees it: denominations, stock, cash.
    // ------------------------------------------------------------------
    logic [DENOM_W-1:0] denom_m [NOTE_SLOTS];
    logic [STOCK_W-1:0] stock_m [NOTE_SLOTS];
    logic [VALUE_W-1:0] cash_m;

    cmd_word_t pending_words [$];   // words waiting for the driver
    payout_t   payout_q [$];        // predicted result words, oldest first

    int     send_idle_pct;
    int     stall_pct;
    bit     word_taken;
    int     queued;
    int     words_sent;
    int     results_seen;
    int     mismatches;
    int     paid_cnt;
    int     refused_cnt;
    int     loaded_cnt;
    longint cycles;

    // Planned stock per slot, used only to shape payable withdraws.
    int     gen_stock [NOTE_SLOTS];

    // Greedy payout: highest slot first, each slot capped by its stock.
    // A withdraw that cannot be paid exactly leaves everything untouched.
    function automatic payout_t dispense(cmd_word_t w);
        payout_t            r;
        logic [VALUE_W-1:0] rem;
        logic [VALUE_W-1:0] n;
        r = '0;
        case (w.cmd)
            CMD_WITHDRAW:
            begin
                if (w.value > cash_m)
                    r.status = STAT_REFUSED;
                else
                begin
                    rem = w.value;
                    for (int i = NOTE_SLOTS - 1; i >= 0; i--)
                    begin
                        n = '0;
                        // zero denomination gives no notes
                        if (denom_m[i] != '0)
                        begin
                            n = rem / denom_m[i];
                            if (n > stock_m[i])
                                n = stock_m[i];
                        end
                        r.notes[i] = n[STOCK_W-1:0];
                        rem = rem - n * denom_m[i];
                    end
                    if (rem == '0)
                    begin
                        r.status = STAT_PAID;
                        r.paid   = w.value;
                        for (int i = 0; i < NOTE_SLOTS; i++)
                            stock_m[i] = stock_m[i] - r.notes[i];
                        cash_m = cash_m - w.value;
                    end
                    else
                    begin
                        r.status = STAT_REFUSED;
                        r.notes  = '0;
                    end
                end
            end
            CMD_SET_STOCK:
            begin
                r.status = STAT_LOADED;
                // slot 6 and 7 are accepted but change nothing
                if (w.slot < NOTE_SLOTS)
                    stock_m[w.slot] = (w.value > STOCK_CAP) ? '1 : w.value[STOCK_W-1:0];
            end
            CMD_SET_CASH:
            begin
                r.status = STAT_LOADED;
                cash_m   = w.value;
            end
            default:
                r.status = STAT_REFUSED;
        endcase
        // lowest stocked slot wins, so scan downward and keep the last hit
        r.smallest = '0;
        for (int i = NOTE_SLOTS - 1; i >= 0; i--)
            if (stock_m[i] != '0)
                r.smallest = denom_m[i];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Command side: accept at the rising edge, drive at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : word_accept
        cmd_word_t w;
        word_taken = rst_n && req_if.valid && req_if.ready;
        if (word_taken)
        begin
            w.cmd   = req_if.cmd;
            w.slot  = req_if.slot;
            w.value = req_if.value;
            payout_q.push_back(dispense(w));
            words_sent++;
        end
    end

    always @(negedge clk)
    begin : word_driver
        cmd_word_t w;
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || word_taken)
        begin
            // a word is held until taken; a new one may follow back to back
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                req_if.valid <= 1'b1;
                req_if.cmd   <= w.cmd;
                req_if.slot  <= w.slot;
                req_if.value <= w.value;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare each word in order.
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : result_monitor
        payout_t got;
        payout_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.status   = rsp_if.status;
            got.notes[0] = rsp_if.notes_slot0;
            got.notes[1] = rsp_if.notes_slot1;
            got.notes[2] = rsp_if.notes_slot2;
            got.notes[3] = rsp_if.notes_slot3;
            got.notes[4] = rsp_if.notes_slot4;
            got.notes[5] = rsp_if.notes_slot5;
            got.paid     = rsp_if.paid_total;
            got.smallest = rsp_if.smallest_note;
            if (payout_q.size() == 0)
                report_mismatch("word with nothing pending", got.status, 0);
            else
            begin
                want = payout_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                for (int i = 0; i < NOTE_SLOTS; i++)
                    if (got.notes[i] !== want.notes[i])
                        report_mismatch($sformatf("notes_slot%0d", i),
                                        got.notes[i], want.notes[i]);
                if (got.paid !== want.paid)
                    report_mismatch("paid_total", got.paid, want.paid);
                if (got.smallest !== want.smallest)
                    report_mismatch("smallest_note", got.smallest, want.smallest);
                case (want.status)
                    STAT_PAID:    paid_cnt++;
                    STAT_REFUSED: refused_cnt++;
                    default:      loaded_cnt++;
                endcase
            end
            results_seen++;
        end
    end

    // Watchdog: far above the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles: %0d words unsent, %0d results outstanding",
                     cycles, pending_words.size(), payout_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[VALUE_W-1:0];
    endfunction

    task automatic queue_word(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                              logic [VALUE_W-1:0] v);
        cmd_word_t w;
        w.cmd   = c;
        w.slot  = s;
        w.value = v;
        pending_words.push_back(w);
        queued++;
    endtask

    // Register write; the model follows at once since the block is idle.
    task automatic write_denom(int idx, logic [DENOM_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= data;
        if (idx < NOTE_SLOTS)
            denom_m[idx] = data;
    endtask

    task automatic load_denoms(int p);
        logic [DENOM_W-1:0] d;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            case (p)
                1:       d = DENOM_COINS[i];
                2:       d = DENOM_EDGES[i];
                3:       d = $urandom_range(1, DENOM_MAX);
                4:       d = (i + 1) * $urandom_range(1, 200);
                5:       d = DENOM_MAX;
                6:       d = ($urandom_range(3) == 0) ? '0 : $urandom_range(0, DENOM_MAX);
                default: d = DENOM_RESET[i];
            endcase
            write_denom(i, d);
        end
        // indexes past the last slot must be ignored
        if (p == 2 || p == 6)
        begin
            write_denom(NOTE_SLOTS, $urandom_range(0, DENOM_MAX));
            write_denom(NOTE_SLOTS + 1, $urandom_range(0, DENOM_MAX));
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hand-picked words on the reset denominations (10000 .. 500000).
    task automatic queue_directed();
        queue_word(CMD_WITHDRAW, 0, 0);               // zero amount, empty machine
        queue_word(CMD_WITHDRAW, 0, 10000);           // above a zero cash total
        queue_word(CMD_UNUSED, 7, VALUE_MAX);         // unknown command
        queue_word(CMD_SET_CASH, 0, VALUE_MAX);
        queue_word(CMD_SET_STOCK, 0, VALUE_MAX);      // stock saturates
        queue_word(CMD_SET_STOCK, 6, 5);              // slot out of range
        queue_word(CMD_SET_STOCK, 7, 5);
        queue_word(CMD_SET_STOCK, 5, 2);
        queue_word(CMD_SET_STOCK, 4, 36'h10000);      // just past the cap
        queue_word(CMD_SET_STOCK, 3, STOCK_CAP);
        queue_word(CMD_SET_STOCK, 2, 1);
        queue_word(CMD_WITHDRAW, 0, 1);               // cannot be made exactly
        queue_word(CMD_WITHDRAW, 0, 1_234_560_000);   // slot 5 runs dry, rest fill in
        queue_word(CMD_WITHDRAW, 0, VALUE_MAX);       // now above cash total
        queue_word(CMD_SET_STOCK, 0, 0);              // smallest note moves up
        queue_word(CMD_SET_CASH, 7, 100000);
        queue_word(CMD_WITHDRAW, 0, 100001);          // one above cash total
        queue_word(CMD_WITHDRAW, 0, 100000);          // equal to cash total
        queue_word(CMD_WITHDRAW, 0, 0);               // zero amount, zero cash
        queue_word(CMD_SET_STOCK, 1, 3);
        queue_word(CMD_SET_CASH, 0, 60000);
        queue_word(CMD_WITHDRAW, 0, 60000);           // empties slot 1
    endtask

    // Mostly restock / set cash / payable withdraws; the rest is noise.
    task automatic queue_random_words(int count);
        int                 first;
        int                 k;
        int                 pick;
        logic [VALUE_W-1:0] s;
        logic [VALUE_W-1:0] cash;
        longint unsigned    amt;
        longint unsigned    planned;
        longint unsigned    amounts [$];
        first = queued;
        while (queued - first < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                for (int i = 0; i < NOTE_SLOTS; i++)
                begin
                    if ($urandom_range(4) != 0)
                    begin
                        pick = $urandom_range(19);
                        if (pick < 12)
                            s = $urandom_range(0, 40);
                        else if (pick < 15)
                            s = '0;
                        else if (pick < 18)
                            s = $urandom_range(0, 65535);
                        else
                            s = rand_value();
                        queue_word(CMD_SET_STOCK, SLOT_W'(i), s);
                        gen_stock[i] = (s > STOCK_CAP) ? 65535 : int'(s);
                    end
                end
                planned = 0;
                amounts.delete();
                repeat ($urandom_range(1, 4))
                begin
                    amt = 0;
                    for (int i = 0; i < NOTE_SLOTS; i++)
                    begin
                        k = $urandom_range(0, (gen_stock[i] > 600) ? 300 : gen_stock[i] / 2);
                        amt += longint'(k) * denom_m[i];
                        gen_stock[i] -= k;
                    end
                    amounts.push_back(amt);
                    planned += amt;
                end
                // exact, one short, some slack, or everything
                case ($urandom_range(3))
                    0:       cash = planned;
                    1:       cash = (planned != 0) ? planned - 1 : 0;
                    2:       cash = planned + $urandom_range(0, 1000000);
                    default: cash = VALUE_MAX;
                endcase
                queue_word(CMD_SET_CASH, $urandom_range(7), cash);
                foreach (amounts[j])
                    queue_word(CMD_WITHDRAW, $urandom_range(7), amounts[j]);
            end
            else
            begin
                case ($urandom_range(3))
                    0: queue_word($urandom_range(3), $urandom_range(7), rand_value());
                    1: queue_word(CMD_WITHDRAW, $urandom_range(7), $urandom_range(0, 2000000));
                    2: queue_word(CMD_WITHDRAW, $urandom_range(7),
                                  denom_m[$urandom_range(NOTE_SLOTS - 1)] * $urandom_range(1, 5));
                    default: queue_word(CMD_UNUSED, $urandom_range(7), rand_value());
                endcase
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || req_if.valid || payout_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, then phases of idle/stall mix and denominations.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_if.valid  = 1'b0;
        req_if.cmd    = '0;
        req_if.slot   = '0;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        word_taken    = 1'b0;
        queued        = 0;
        words_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        paid_cnt      = 0;
        refused_cnt   = 0;
        loaded_cnt    = 0;
        cycles        = 0;
        cash_m        = '0;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            denom_m[i]   = DENOM_RESET[i];
            stock_m[i]   = '0;
            gen_stock[i] = 0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // no idling, sender idle, receiver stalls, then both mixed
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 64; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            // phase 0 runs on the reset denominations; the rest rewrite them
            if (p == 0)
                queue_directed();
            else
                load_denoms(p);
            queue_random_words(PHASE_WORDS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d command words in %0d phases over idle/stall mixes and %0d denomination sets.",
                 words_sent, PHASES, PHASES);
        $display("Checked %0d result words: %0d paid, %0d refused, %0d loads; %0d mismatches.",
                 results_seen, paid_cnt, refused_cnt, loaded_cnt, mismatches);
        if (mismatches == 0 && payout_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
